FILE: rtl/core/interpolation_point_checker_defines.svh
// Assertion macros for the interpolation point checker.
`ifndef INTERPOLATION_POINT_CHECKER_DEFINES_SVH
`define INTERPOLATION_POINT_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define IPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define IPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPC_ASSERT(label, prop, msg)
`define IPC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/core/ipc_pkg.sv
// Types, constants and result codes of the interpolation point checker.
package ipc_pkg;

    // Time units per second used to scale a per-period difference.
    localparam int TICKS_PER_SECOND = 10000;

    localparam int POS_W   = 32;
    localparam int MAG_W   = POS_W + 1;
    localparam int PER_W   = 16;
    localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W  = MAG_W + TPS_W;
    // Divider retires two quotient bits a cycle, so the dividend is padded to even.
    localparam int DIV_W      = 2 * ((PROD_W + 1) / 2);
    localparam int DIV_CYCLES = DIV_W / 2;
    localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int CODE_W = 3;
    localparam logic [CODE_W-1:0] CODE_OK    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_START = 3'd1;
    localparam logic [CODE_W-1:0] CODE_POS   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_VEL   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_ACC   = 3'd4;

    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [IDX_W-1:0] REG_PERIOD    = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_WIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_VEL = 3'd3;
    localparam logic [IDX_W-1:0] REG_POS_MAX   = 3'd4;
    localparam logic [IDX_W-1:0] REG_POS_MIN   = 3'd5;
    localparam logic [IDX_W-1:0] REG_VEL_LIM   = 3'd6;
    localparam logic [IDX_W-1:0] REG_ACC_LIM   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_EVAL,
        ST_DONE
    } state_t;

    // Exact magnitude of the difference of two signed 32-bit values.
    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                  input logic signed [POS_W-1:0] b);
        logic signed [MAG_W-1:0] d;
        d = MAG_W'(a) - MAG_W'(b);
        return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    endfunction

endpackage

FILE: rtl/core/interpolation_point_checker.sv
// Interpolation point checker: setpoint window, limit, velocity and acceleration checks.
// A failing start, position or point velocity check hands on its result without any scaling;
// otherwise one scaled rate decides, or two if linear mode also scales the mean velocity change;
// each scaled rate is a constant multiply followed by a radix-4 divider.
// One word in work at a time: the next is taken once the result sits in the output register.
// Reset (rst_n, async, active low) loads register defaults and clears the stored mean velocity.
module interpolation_point_checker
    import ipc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [POS_W-1:0]          cfg_data,
    // input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      is_start,
    input  logic signed [POS_W-1:0]   pos_a,
    input  logic signed [POS_W-1:0]   vel_a,
    input  logic signed [POS_W-1:0]   pos_b,
    input  logic signed [POS_W-1:0]   vel_b,
    input  logic signed [POS_W-1:0]   actual_pos,
    input  logic                      at_min_switch,
    input  logic                      at_max_switch,
    // output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [CODE_W-1:0]         check_code
);

`include "interpolation_point_checker_defines.svh"

    localparam logic [TPS_W-1:0] TPS_VAL  = TPS_W'(TICKS_PER_SECOND);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

    // configuration registers
    logic                     mode_reg;
    logic [PER_W-1:0]         period_reg;
    logic [POS_W-1:0]         start_win_reg;
    logic [POS_W-1:0]         start_vel_reg;
    logic signed [POS_W-1:0]  pos_max_reg;
    logic signed [POS_W-1:0]  pos_min_reg;
    logic [POS_W-1:0]         vel_lim_reg;
    logic [POS_W-1:0]         acc_lim_reg;

    // captured input word
    logic                     start_reg;
    logic signed [POS_W-1:0]  pos_a_reg;
    logic signed [POS_W-1:0]  vel_a_reg;
    logic signed [POS_W-1:0]  pos_b_reg;
    logic signed [POS_W-1:0]  vel_b_reg;
    logic signed [POS_W-1:0]  act_reg;
    logic                     sw_min_reg;
    logic                     sw_max_reg;

    // sequencer and datapath
    state_t                   state_reg, state_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [DIV_W-1:0]         dq_reg, dq_next;
    logic [PER_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     phase_reg, phase_next;
    logic [MAG_W-1:0]         mean_reg, mean_next;
    logic [MAG_W-1:0]         prev_mean_reg, prev_mean_next;
    logic [CODE_W-1:0]        code_reg, code_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]        check_code_reg, check_code_next;

    // decisions of the check and evaluate steps
    logic                     chk_hit;
    logic [CODE_W-1:0]        chk_code;
    logic                     chk_clear;
    logic [MAG_W-1:0]         chk_mag;
    logic                     ev_done;
    logic [CODE_W-1:0]        ev_code;
    logic                     ev_save;
    logic [MAG_W-1:0]         ev_mag;

    logic [PER_W-1:0]         per_eff;
    logic                     out_free;
    logic                     accept;
    logic [DIV_W-1:0]         vel_lim_ext;
    logic [DIV_W-1:0]         acc_lim_ext;
    logic [PER_W-1:0]         div_rem;
    logic [DIV_W-1:0]         div_dq;

    // A zero period behaves as a period of one.
    assign per_eff     = (period_reg == '0) ? PER_W'(1) : period_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign accept      = in_valid && !in_stall;
    assign vel_lim_ext = DIV_W'(vel_lim_reg);
    assign acc_lim_ext = DIV_W'(acc_lim_reg);

    // Front checks: start window, start velocity, position limits, switches,
    // point velocities. First failing check sets the code.
    always_comb
    begin
        logic [MAG_W-1:0] start_dist;
        logic [MAG_W-1:0] va_mag;
        logic [MAG_W-1:0] vb_mag;
        logic             pos_bad;
        start_dist = abs_diff(pos_a_reg, act_reg);
        va_mag     = abs_diff(vel_a_reg, '0);
        vb_mag     = abs_diff(vel_b_reg, '0);
        pos_bad    = (pos_b_reg > pos_max_reg) || (pos_b_reg < pos_min_reg)
                  || (sw_min_reg && (pos_b_reg < pos_a_reg))
                  || (sw_max_reg && (pos_b_reg > pos_a_reg));
        chk_hit   = 1'b0;
        chk_code  = CODE_OK;
        chk_clear = 1'b0;
        chk_mag   = mode_reg ? abs_diff(vel_b_reg, vel_a_reg) : abs_diff(pos_b_reg, pos_a_reg);
        if (start_reg && (start_dist > MAG_W'(start_win_reg)))
        begin
            chk_hit  = 1'b1;
            chk_code = CODE_START;
        end
        else if (start_reg && mode_reg && (va_mag > MAG_W'(start_vel_reg)))
        begin
            chk_hit  = 1'b1;
            chk_code = CODE_START;
        end
        else
        begin
            // Linear start segment drops the stored mean even if a later check fails.
            chk_clear = start_reg && !mode_reg;
            if (pos_bad)
            begin
                chk_hit  = 1'b1;
                chk_code = CODE_POS;
            end
            else if (mode_reg && ((va_mag > MAG_W'(vel_lim_reg))
                                  || (vb_mag > MAG_W'(vel_lim_reg))))
            begin
                chk_hit  = 1'b1;
                chk_code = CODE_VEL;
            end
        end
    end

    // Two restoring division steps per cycle; quotient bits shift in behind the dividend.
    always_comb
    begin
        logic [PER_W:0] sh;
        logic           qb;
        div_rem = rem_reg;
        div_dq  = dq_reg;
        for (int i = 0; i < 2; i++)
        begin
            sh = {div_rem, div_dq[DIV_W-1]};
            qb = (sh >= {1'b0, per_eff});
            div_rem = qb ? PER_W'(sh - {1'b0, per_eff}) : PER_W'(sh);
            div_dq  = {div_dq[DIV_W-2:0], qb};
        end
    end

    // Evaluate a finished quotient: cubic acceleration, linear mean velocity
    // (first pass) or linear mean acceleration (second pass).
    always_comb
    begin
        logic [MAG_W-1:0] q_low;
        q_low   = dq_reg[MAG_W-1:0];
        ev_done = 1'b1;
        ev_code = CODE_OK;
        ev_save = 1'b0;
        ev_mag  = (q_low >= prev_mean_reg) ? (q_low - prev_mean_reg) : (prev_mean_reg - q_low);
        if (!mode_reg && !phase_reg)
        begin
            if (dq_reg > vel_lim_ext)
            begin
                ev_code = CODE_VEL;
            end
            else
            begin
                ev_done = 1'b0;
            end
        end
        else if (dq_reg > acc_lim_ext)
        begin
            ev_code = CODE_ACC;
        end
        else
        begin
            ev_save = !mode_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_CHECK;
            ST_CHECK: state_next = chk_hit ? ST_DONE : ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == CNT_LAST) state_next = ST_EVAL;
            ST_EVAL:  state_next = ev_done ? ST_DONE : ST_MUL;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and output controls
    always_comb
    begin
        in_stall        = (state_reg != ST_IDLE);
        mag_next        = mag_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        mean_next       = mean_reg;
        prev_mean_next  = prev_mean_reg;
        code_next       = code_reg;
        out_valid_next  = out_valid_reg && out_stall;
        check_code_next = check_code_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                phase_next = 1'b0;
            end
            ST_CHECK:
            begin
                mag_next  = chk_mag;
                code_next = chk_code;
                if (chk_clear)
                begin
                    prev_mean_next = '0;
                end
            end
            ST_MUL:
            begin
                // constant multiply; the product waits in the dividend register
                dq_next  = DIV_W'(mag_reg) * DIV_W'(TPS_VAL);
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                dq_next  = div_dq;
                rem_next = div_rem;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_EVAL:
            begin
                code_next = ev_code;
                if (!ev_done)
                begin
                    // hold the mean and run the second scaling on its change
                    mean_next  = dq_reg[MAG_W-1:0];
                    mag_next   = ev_mag;
                    phase_next = 1'b1;
                end
                if (ev_save)
                begin
                    prev_mean_next = mean_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    check_code_next = code_reg;
                end
            end
            default:
            begin
                phase_next = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            period_reg    <= PER_W'(1);
            start_win_reg <= '0;
            start_vel_reg <= '0;
            pos_max_reg   <= {1'b0, {(POS_W-1){1'b1}}};
            pos_min_reg   <= {1'b1, {(POS_W-1){1'b0}}};
            vel_lim_reg   <= '0;
            acc_lim_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[0];
                REG_PERIOD:    period_reg    <= cfg_data[PER_W-1:0];
                REG_START_WIN: start_win_reg <= cfg_data;
                REG_START_VEL: start_vel_reg <= cfg_data;
                REG_POS_MAX:   pos_max_reg   <= cfg_data;
                REG_POS_MIN:   pos_min_reg   <= cfg_data;
                REG_VEL_LIM:   vel_lim_reg   <= cfg_data;
                REG_ACC_LIM:   acc_lim_reg   <= cfg_data;
                default:       mode_reg      <= mode_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            prev_mean_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            prev_mean_reg <= prev_mean_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg  <= is_start;
            pos_a_reg  <= pos_a;
            vel_a_reg  <= vel_a;
            pos_b_reg  <= pos_b;
            vel_b_reg  <= vel_b;
            act_reg    <= actual_pos;
            sw_min_reg <= at_min_switch;
            sw_max_reg <= at_max_switch;
        end
        mag_reg        <= mag_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        mean_reg       <= mean_next;
        code_reg       <= code_next;
        check_code_reg <= check_code_next;
    end

    assign out_valid  = out_valid_reg;
    assign check_code = check_code_reg;

    // An accepted word closes the input until its result is handed on.
    `IPC_ASSERT(a_busy_after_accept, accept |=> in_stall, "input open right after accept")
    // A stored mean never exceeds a 32-bit velocity limit.
    `IPC_ASSERT(a_prev_mean_range, !prev_mean_reg[MAG_W-1], "stored mean velocity overflow")
    // Divider runs only with a zeroed remainder at its first step.
    `IPC_ASSERT(a_div_start, (state_reg == ST_MUL) |=> (rem_reg == '0) && (cnt_reg == '0),
                "divider not initialized")
    // Results carry only defined codes.
    `IPC_ASSERT_ALWAYS(a_code_range, out_valid |-> (check_code <= CODE_ACC),
                       "undefined result code")

endmodule
